// File: rtl/bads_pkg.sv
// ----------------------------------------------------------------------------
// Block average downscaler package
// Shared widths, register indexes, defaults and the status bundle of the
// queue that sits between the front and back parts.
// ----------------------------------------------------------------------------
package bads_pkg;

   localparam int PIXEL_W      = 8;
   localparam int WIDTH_CFG_W  = 13;
   localparam int HEIGHT_CFG_W = 13;
   localparam int SCALE_CFG_W  = 4;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_W        = 12;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_SCALE  = 2;

   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_SCALE = 8;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SCALE        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } queue_status_type;

endpackage

// File: rtl/bads_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bads_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bads_front.sv
// ----------------------------------------------------------------------------
// Block average downscaler front part
// Holds configuration, tracks the frame position, accumulates tile column
// sums in the line store and hands finished tile sums to the queue.
// ----------------------------------------------------------------------------
module bads_front #(
   parameter int MAX_WIDTH = bads_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = bads_pkg::DEF_MAX_SCALE
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write,
   input  logic [bads_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [bads_pkg::CSR_DATA_W-1:0]           csr_wdata,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [bads_pkg::PIXEL_W-1:0]              req_pixel,
   input  bads_pkg::queue_status_type                queue_status,
   output logic                                      push_valid,
   output logic [bads_pkg::PIXEL_W+2*$clog2(MAX_SCALE)-1:0] push_sum,
   output logic                                      push_last,
   output logic [$clog2(MAX_SCALE):0]                scale_eff
);

   import bads_pkg::*;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int PH_W      = $clog2(MAX_SCALE);
   localparam int SCL_W     = PH_W + 1;
   localparam int ROW_SUM_W = PIXEL_W + PH_W;
   localparam int TILE_W    = PIXEL_W + 2 * PH_W;
   localparam int WIDTH_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   // configuration, already clamped
   logic [COL_W:0]            width_ff, width_in;
   logic [HEIGHT_CFG_W-1:0]   height_ff, height_in;
   logic [SCL_W-1:0]          scale_ff, scale_in;

   // frame position
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [PH_W-1:0]           cphase_ff, cphase_in;
   logic [PH_W-1:0]           rphase_ff, rphase_in;
   logic [COL_W-1:0]          tcol_ff, tcol_in;
   logic [ROW_SUM_W-1:0]      row_sum_ff, row_sum_in;

   // line store update stage
   logic                      st1_valid_ff, st1_valid_in;
   logic                      st1_emit_ff, st1_emit_in;
   logic                      st1_last_ff, st1_last_in;
   logic                      st1_first_ff, st1_first_in;
   logic [COL_W-1:0]          st1_tx_ff, st1_tx_in;
   logic [ROW_SUM_W-1:0]      st1_sum_ff, st1_sum_in;
   logic                      fwd_ff, fwd_in;
   logic [TILE_W-1:0]         fwd_data_ff, fwd_data_in;

   logic [WIDTH_CFG_W-1:0]    raw_width;
   logic [HEIGHT_CFG_W-1:0]   raw_height;
   logic [SCALE_CFG_W-1:0]    raw_scale;
   logic [COL_W:0]            width_new;
   logic [HEIGHT_CFG_W-1:0]   height_new;
   logic [SCL_W-1:0]          scale_new;
   logic                      csr_hit;

   logic                      accept;
   logic [ROW_SUM_W-1:0]      sum;
   logic                      last_col;
   logic                      last_row;
   logic                      tile_end_h;
   logic                      tile_end_v;
   logic [SCL_W-1:0]          cphase_inc;
   logic [SCL_W-1:0]          rphase_inc;
   logic                      rd_en;
   logic [TILE_W-1:0]         ram_rdata;
   logic [TILE_W-1:0]         prev_sum;
   logic [TILE_W-1:0]         acc;

   // clamp incoming register values
   assign raw_width  = csr_wdata[WIDTH_CFG_W-1:0];
   assign raw_height = csr_wdata[HEIGHT_CFG_W-1:0];
   assign raw_scale  = csr_wdata[SCALE_CFG_W-1:0];

   always_comb begin
      if (raw_width == '0) begin
         width_new = (COL_W+1)'(1);
      end else if (32'(raw_width) > 32'(MAX_WIDTH)) begin
         width_new = (COL_W+1)'(MAX_WIDTH);
      end else begin
         width_new = (COL_W+1)'(raw_width);
      end
      if (raw_height == '0) begin
         height_new = HEIGHT_CFG_W'(1);
      end else if (32'(raw_height) > 32'(HEIGHT_LIMIT)) begin
         height_new = HEIGHT_CFG_W'(HEIGHT_LIMIT);
      end else begin
         height_new = raw_height;
      end
      if (raw_scale == '0) begin
         scale_new = SCL_W'(1);
      end else if (32'(raw_scale) > 32'(MAX_SCALE)) begin
         scale_new = SCL_W'(MAX_SCALE);
      end else begin
         scale_new = SCL_W'(raw_scale);
      end
   end

   assign req_stall = !queue_status.has_room;
   assign accept    = req_valid && !req_stall;

   assign sum        = row_sum_ff + ROW_SUM_W'(req_pixel);
   assign last_col   = ((COL_W+1)'(col_ff) + (COL_W+1)'(1)) >= width_ff;
   assign last_row   = (HEIGHT_CFG_W'(row_ff) + HEIGHT_CFG_W'(1)) >= height_ff;
   assign cphase_inc = SCL_W'(cphase_ff) + SCL_W'(1);
   assign rphase_inc = SCL_W'(rphase_ff) + SCL_W'(1);
   assign tile_end_h = (cphase_inc >= scale_ff) || last_col;
   assign tile_end_v = (rphase_inc >= scale_ff) || last_row;

   // first row of a tile row starts from zero, so skip the read there
   assign rd_en = accept && tile_end_h && (rphase_ff != '0);

   assign prev_sum = fwd_ff ? fwd_data_ff : ram_rdata;
   assign acc      = (st1_first_ff ? '0 : prev_sum) + TILE_W'(st1_sum_ff);

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      scale_in     = scale_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cphase_in    = cphase_ff;
      rphase_in    = rphase_ff;
      tcol_in      = tcol_ff;
      row_sum_in   = row_sum_ff;
      st1_valid_in = 1'b0;
      fwd_in       = 1'b0;
      st1_emit_in  = tile_end_v;
      st1_last_in  = last_row && last_col;
      st1_first_in = (rphase_ff == '0);
      st1_tx_in    = tcol_ff;
      st1_sum_in   = sum;
      fwd_data_in  = acc;
      csr_hit      = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = width_new;
               csr_hit  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = height_new;
               csr_hit   = 1'b1;
            end
            CSR_SCALE: begin
               scale_in = scale_new;
               csr_hit  = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end

      if (csr_hit) begin
         // restart the frame
         col_in     = '0;
         row_in     = '0;
         cphase_in  = '0;
         rphase_in  = '0;
         tcol_in    = '0;
         row_sum_in = '0;
      end else if (accept) begin
         st1_valid_in = tile_end_h;
         fwd_in       = tile_end_h && st1_valid_ff && (st1_tx_ff == tcol_ff);
         row_sum_in   = tile_end_h ? '0 : sum;
         if (last_col) begin
            col_in    = '0;
            cphase_in = '0;
            tcol_in   = '0;
            if (last_row) begin
               row_in    = '0;
               rphase_in = '0;
            end else begin
               row_in    = row_ff + ROW_W'(1);
               rphase_in = (rphase_inc >= scale_ff) ? '0 : PH_W'(rphase_inc);
            end
         end else begin
            col_in    = col_ff + COL_W'(1);
            cphase_in = tile_end_h ? '0 : PH_W'(cphase_inc);
            tcol_in   = tile_end_h ? tcol_ff + COL_W'(1) : tcol_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= (COL_W+1)'(WIDTH_RST);
         height_ff    <= HEIGHT_CFG_W'(RESET_HEIGHT);
         scale_ff     <= SCL_W'(RESET_SCALE);
         col_ff       <= '0;
         row_ff       <= '0;
         cphase_ff    <= '0;
         rphase_ff    <= '0;
         tcol_ff      <= '0;
         row_sum_ff   <= '0;
         st1_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         scale_ff     <= scale_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cphase_ff    <= cphase_in;
         rphase_ff    <= rphase_in;
         tcol_ff      <= tcol_in;
         row_sum_ff   <= row_sum_in;
         st1_valid_ff <= st1_valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      st1_emit_ff  <= st1_emit_in;
      st1_last_ff  <= st1_last_in;
      st1_first_ff <= st1_first_in;
      st1_tx_ff    <= st1_tx_in;
      st1_sum_ff   <= st1_sum_in;
      fwd_data_ff  <= fwd_data_in;
   end

   bads_ram #(
      .WIDTH (TILE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (st1_valid_ff),
      .wr_addr (st1_tx_ff),
      .wr_data (acc),
      .rd_en   (rd_en),
      .rd_addr (tcol_ff),
      .rd_data (ram_rdata)
   );

   assign push_valid = st1_valid_ff && st1_emit_ff;
   assign push_sum   = acc;
   assign push_last  = st1_last_ff;
   assign scale_eff  = scale_ff;

   a_phase_in_tile: assert property (@(posedge clock) disable iff (reset)
      (SCL_W'(cphase_ff) < scale_ff) && (SCL_W'(rphase_ff) < scale_ff))
      else $error("tile phase reached the scale");

   a_fwd_with_update: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> st1_valid_ff)
      else $error("line store bypass without an update in flight");

endmodule

// File: rtl/bads_queue.sv
// ----------------------------------------------------------------------------
// Block average downscaler queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module bads_queue #(
   parameter int WIDTH = 15,
   parameter int DEPTH = bads_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output bads_pkg::queue_status_type status
);

   import bads_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data        = mem_ff[rd_ptr_ff];
   assign status.has_item = (count_ff != '0);
   // room for the item being pushed now and one more behind it
   assign status.has_room = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(push))
                            <= (CNT_W+1)'(DEPTH - 2);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)) || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

endmodule

// File: rtl/bads_back.sv
// ----------------------------------------------------------------------------
// Block average downscaler back part
// Divides each tile sum by scale squared through a reciprocal multiply and
// drives the result channel from an output register.
// ----------------------------------------------------------------------------
module bads_back #(
   parameter int MAX_SCALE = bads_pkg::DEF_MAX_SCALE
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [$clog2(MAX_SCALE):0]                   scale,
   input  bads_pkg::queue_status_type                   queue_status,
   input  logic [bads_pkg::PIXEL_W+2*$clog2(MAX_SCALE):0] queue_data,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [bads_pkg::PIXEL_W-1:0]                 rsp_average,
   output logic                                         rsp_frame_last
);

   import bads_pkg::*;

   localparam int PH_W    = $clog2(MAX_SCALE);
   localparam int TILE_W  = PIXEL_W + 2 * PH_W;
   localparam int SHIFT   = TILE_W + 2 * PH_W;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = TILE_W + RECIP_W;

   logic [RECIP_W-1:0] recip_tab [MAX_SCALE];
   logic [PH_W-1:0]    recip_idx;
   logic [RECIP_W-1:0] recip;

   logic               mul_valid_ff, mul_valid_in;
   logic [PROD_W-1:0]  mul_product_ff, mul_product_in;
   logic               mul_last_ff, mul_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_average_ff, rsp_average_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_ready;
   logic               mul_ready;

   // ceil(2^SHIFT / (s*s)) for every scale, exact for every tile sum
   for (genvar g = 1; g <= MAX_SCALE; g++) begin : g_recip
      localparam longint unsigned DIVISOR = longint'(g) * longint'(g);
      localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
      assign recip_tab[g-1] = RECIP_W'(RECIP);
   end

   assign recip_idx = PH_W'(scale - 1'b1);
   assign recip     = recip_tab[recip_idx];

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign mul_ready = !mul_valid_ff || out_ready;
   assign pop       = queue_status.has_item && mul_ready;

   always_comb begin
      mul_valid_in   = mul_valid_ff;
      mul_product_in = mul_product_ff;
      mul_last_in    = mul_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_last_in    = rsp_last_ff;
      if (out_ready) begin
         rsp_valid_in   = mul_valid_ff;
         rsp_average_in = mul_product_ff[SHIFT +: PIXEL_W];
         rsp_last_in    = mul_last_ff;
         mul_valid_in   = 1'b0;
      end
      if (pop) begin
         mul_valid_in   = 1'b1;
         mul_product_in = PROD_W'(queue_data[TILE_W-1:0]) * PROD_W'(recip);
         mul_last_in    = queue_data[TILE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_product_ff <= mul_product_in;
      mul_last_ff    <= mul_last_in;
      rsp_average_ff <= rsp_average_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_average_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_hold_product: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && !out_ready |=> mul_valid_ff && $stable(mul_product_ff))
      else $error("product lost while the output was stalled");

endmodule

// File: rtl/block_average_downscale_unit.sv
// ----------------------------------------------------------------------------
// Block average downscale unit
// Box filter downscaler for 8-bit gray frames by an integer tile size.
// ----------------------------------------------------------------------------
// Usage:
//  - Feed pixels in raster order on req_valid / req_stall / req_pixel; an item
//    is taken on a clock edge with req_valid high and req_stall low.
//  - One averaged item per tile leaves on rsp_valid / rsp_stall, in output
//    raster order; rsp_frame_last marks the final tile of the frame. Edge
//    tiles count missing pixels as zero but still divide by scale squared.
//  - Program image_width, image_height and scale through csr_write /
//    csr_index / csr_wdata only while idle; any valid write restarts the frame.
//  - Throughput: one pixel per cycle, sustained while req_stall stays low, and up
//    to one result per cycle; the line store sees one read and one write a cycle.
//  - The result of a tile passes the line store update stage, the queue, the
//    reciprocal multiply and the output register after its last pixel is taken.
//  - When rsp_stall is high the result holds; the multiply stage and up to
//    three tiles in the four-entry queue soak up further results, then
//    req_stall rises.
//  - Reset: 640 x 480, scale 2, frame position at the start. The line store
//    is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module block_average_downscale_unit #(
   parameter int MAX_WIDTH = bads_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE = bads_pkg::DEF_MAX_SCALE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [bads_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bads_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bads_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bads_pkg::PIXEL_W-1:0]     rsp_average,
   output logic                             rsp_frame_last
);

   import bads_pkg::*;

   localparam int PH_W   = $clog2(MAX_SCALE);
   localparam int TILE_W = PIXEL_W + 2 * PH_W;

   queue_status_type   queue_status;
   logic               push_valid;
   logic [TILE_W-1:0]  push_sum;
   logic               push_last;
   logic [PH_W:0]      scale_eff;
   logic               pop;
   logic [TILE_W:0]    queue_data;

   // front: position tracking and tile column sums
   bads_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_sum     (push_sum),
      .push_last    (push_last),
      .scale_eff    (scale_eff)
   );

   // hold finished tile sums until the back part takes them
   bads_queue #(
      .WIDTH (TILE_W + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_last, push_sum}),
      .pop       (pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   // back: divide by scale squared and drive the result channel
   bads_back #(
      .MAX_SCALE (MAX_SCALE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .scale          (scale_eff),
      .queue_status   (queue_status),
      .queue_data     (queue_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
